// File: sv/hbis_pkg.sv
// shared constants and request codes for the hierarchical bitmap integer set
package hbis_pkg;
   localparam int WORD_BITS    = 64;
   localparam int MAX_UNIVERSE = 4096;
   localparam int LEAF_WORDS   = MAX_UNIVERSE / WORD_BITS;
   localparam int BIT_W        = $clog2(WORD_BITS);
   localparam int WIDX_W       = $clog2(LEAF_WORDS);
   localparam int POS_W        = BIT_W + WIDX_W;
   localparam int KEY_W        = 14;
   localparam int SIZE_W       = 13;
   localparam int OP_W         = 3;

   localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
   localparam logic [OP_W-1:0] OP_ERASE    = 3'd1;
   localparam logic [OP_W-1:0] OP_CONTAINS = 3'd2;
   localparam logic [OP_W-1:0] OP_SUCC     = 3'd3;
   localparam logic [OP_W-1:0] OP_PRED     = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR    = 3'd5;

   typedef logic [WORD_BITS-1:0] word_type;
endpackage

// File: sv/hierarchical_bitmap_integer_set_top.sv
// hierarchical bitmap integer set: top level with leaf memory and sequencer
// A set of integers in 0 .. size-1 (size = csr write value, capped at 4096), held as
// 64 leaf bitmap words in a synchronous memory plus a 64-bit summary word whose bit j
// is set while leaf word j is non-zero. A request is accepted only while the sequencer
// is idle. Insert, erase, contains, clear and any successor or predecessor found
// within the key's own leaf word pass through the leaf state only; a search that moves
// on to another leaf word also passes through the descend state. Each state waits on
// one leaf memory read: one to inspect the key's word and, when the summary points
// elsewhere, one more to descend into the chosen word. Results sit in an output
// register, so the next request is taken while a result waits; the sequencer holds in
// its leaf and descend states while that register is still stalled. Clear and csr
// writes empty the set at once through per-word valid bits, with no sweep.
module hierarchical_bitmap_integer_set_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [hbis_pkg::OP_W-1:0]     req_type,
   input  logic signed [hbis_pkg::KEY_W-1:0] req_key,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_success,
   output logic signed [hbis_pkg::KEY_W-1:0] rsp_answer,
   output logic [hbis_pkg::SIZE_W-1:0]   rsp_member_count,
   input  logic                          csr_we,
   input  logic [hbis_pkg::SIZE_W-1:0]   csr_wdata
);
   import hbis_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LEAF = 2'd1;
   localparam logic [1:0] S_DESC = 2'd2;

   localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_UNIVERSE);
   localparam word_type ONES = '1;

   // lowest set bit, 0 when empty
   function automatic logic [BIT_W-1:0] low_bit(input word_type w);
      logic [BIT_W-1:0] n;
      n = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (w[i]) n = BIT_W'(i);
      end
      return n;
   endfunction

   // highest set bit, 0 when empty
   function automatic logic [BIT_W-1:0] high_bit(input word_type w);
      logic [BIT_W-1:0] n;
      n = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (w[i]) n = BIT_W'(i);
      end
      return n;
   endfunction

   // leaf memory and its valid bits
   word_type mem [LEAF_WORDS];
   logic [LEAF_WORDS-1:0] vld_ff;
   word_type rdata_ff;
   logic rvld_ff;

   // control and state registers
   logic [1:0] state_ff, state_in;
   logic [SIZE_W-1:0] size_ff;
   word_type top_ff;
   logic [SIZE_W-1:0] cnt_ff;
   logic [OP_W-1:0] op_ff;
   logic [POS_W-1:0] pos_ff;
   logic early_ff;          // result known at acceptance (bad key, no candidate, clear or unused code)
   logic [WIDX_W-1:0] jdx_ff;

   logic rsp_valid_ff;
   logic rsp_success_ff;
   logic signed [KEY_W-1:0] rsp_answer_ff;
   logic [SIZE_W-1:0] rsp_member_count_ff;

   // effective size
   logic [SIZE_W-1:0] size_eff;
   assign size_eff = (size_ff > MAX_SIZE) ? MAX_SIZE : size_ff;

   // request decode at acceptance
   logic accept;
   logic key_neg;
   logic [SIZE_W-1:0] key_mag;
   logic key_in_range;
   logic [KEY_W-1:0] succ_p;
   logic [SIZE_W-1:0] pred_q;
   logic [POS_W-1:0] pos_in;
   logic early_in;

   assign accept  = req_valid && !req_stall;
   assign key_neg = req_key[KEY_W-1];
   assign key_mag = req_key[SIZE_W-1:0];
   assign key_in_range = !key_neg && (key_mag < size_eff);
   assign succ_p = key_neg ? '0 : KEY_W'(key_mag) + KEY_W'(1);
   assign pred_q = (key_mag >= size_eff) ? size_eff - SIZE_W'(1) : key_mag - SIZE_W'(1);

   always_comb begin
      pos_in   = key_mag[POS_W-1:0];
      early_in = 1'b0;
      unique case (req_type)
         OP_INSERT, OP_ERASE, OP_CONTAINS: early_in = !key_in_range;
         OP_SUCC: begin
            pos_in   = succ_p[POS_W-1:0];
            early_in = succ_p >= KEY_W'(size_eff);
         end
         OP_PRED: begin
            pos_in   = pred_q[POS_W-1:0];
            early_in = key_neg || (size_eff == '0) || (key_mag == '0);
         end
         default: early_in = 1'b1;
      endcase
   end

   // leaf step
   word_type leaf_w, succ_mask, pred_mask, top_up, top_dn, new_w;
   logic [BIT_W-1:0] bpos;
   logic [WIDX_W-1:0] widx;
   logic bit_set;
   logic [BIT_W-1:0] up_bit, dn_bit;
   assign bpos      = pos_ff[BIT_W-1:0];
   assign widx      = pos_ff[POS_W-1:BIT_W];
   assign leaf_w    = rvld_ff ? rdata_ff : '0;
   assign bit_set   = leaf_w[bpos];
   assign succ_mask = leaf_w & (ONES << bpos);
   assign pred_mask = leaf_w & (ONES >> (BIT_W'(WORD_BITS - 1) - bpos));
   assign top_up    = top_ff & ((ONES << widx) << 1);
   assign top_dn    = top_ff & ~(ONES << widx);
   assign up_bit    = low_bit(top_up);
   assign dn_bit    = high_bit(top_dn);

   // descend step
   logic [POS_W-1:0] desc_r;
   assign desc_r = (op_ff == OP_SUCC) ? {jdx_ff, low_bit(leaf_w)}
                                      : {jdx_ff, high_bit(leaf_w)};

   logic out_busy;
   assign out_busy = rsp_valid_ff && rsp_stall;

   // sequencer outputs
   logic finish, go_desc, do_write, do_clear;
   logic res_success;
   logic signed [KEY_W-1:0] res_answer;
   logic [SIZE_W-1:0] cnt_in;
   word_type top_in;
   logic [WIDX_W-1:0] raddr, jdx_in;
   logic rd_en;

   always_comb begin
      state_in    = state_ff;
      finish      = 1'b0;
      go_desc     = 1'b0;
      do_write    = 1'b0;
      do_clear    = 1'b0;
      res_success = 1'b0;
      res_answer  = '0;
      cnt_in      = cnt_ff;
      top_in      = top_ff;
      new_w       = leaf_w;
      jdx_in      = jdx_ff;
      rd_en       = 1'b0;
      raddr       = pos_in[POS_W-1:BIT_W];
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rd_en    = 1'b1;
               state_in = S_LEAF;
            end
         end
         S_LEAF: begin
            if (!out_busy) begin
               unique case (op_ff)
                  OP_INSERT: begin
                     finish = 1'b1;
                     if (!early_ff && !bit_set) begin
                        new_w       = leaf_w | (word_type'(1) << bpos);
                        do_write    = 1'b1;
                        top_in[widx] = 1'b1;
                        cnt_in      = cnt_ff + SIZE_W'(1);
                        res_success = 1'b1;
                     end
                  end
                  OP_ERASE: begin
                     finish = 1'b1;
                     if (!early_ff && bit_set) begin
                        new_w       = leaf_w & ~(word_type'(1) << bpos);
                        do_write    = 1'b1;
                        top_in[widx] = (new_w != '0);
                        cnt_in      = cnt_ff - SIZE_W'(1);
                        res_success = 1'b1;
                     end
                  end
                  OP_CONTAINS: begin
                     finish      = 1'b1;
                     res_success = !early_ff && bit_set;
                  end
                  OP_SUCC: begin
                     res_answer = KEY_W'(size_eff);
                     if (early_ff) begin
                        finish = 1'b1;
                     end else if (succ_mask != '0) begin
                        finish     = 1'b1;
                        res_answer = KEY_W'({widx, low_bit(succ_mask)});
                     end else if (top_up != '0) begin
                        go_desc = 1'b1;
                        jdx_in  = up_bit[WIDX_W-1:0];
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  OP_PRED: begin
                     res_answer = '1;
                     if (early_ff) begin
                        finish = 1'b1;
                     end else if (pred_mask != '0) begin
                        finish     = 1'b1;
                        res_answer = KEY_W'({widx, high_bit(pred_mask)});
                     end else if (top_dn != '0) begin
                        go_desc = 1'b1;
                        jdx_in  = dn_bit[WIDX_W-1:0];
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     finish   = 1'b1;
                     do_clear = 1'b1;
                     cnt_in   = '0;
                     top_in   = '0;
                  end
                  default: finish = 1'b1;
               endcase
               if (go_desc) begin
                  rd_en    = 1'b1;
                  raddr    = jdx_in;
                  state_in = S_DESC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_DESC: begin
            if (!out_busy) begin
               finish   = 1'b1;
               state_in = S_IDLE;
               if (op_ff == OP_SUCC) begin
                  res_answer = (SIZE_W'(desc_r) < size_eff) ? KEY_W'(desc_r)
                                                             : KEY_W'(size_eff);
               end else begin
                  res_answer = KEY_W'(desc_r);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   // leaf memory: one write and one registered read
   always_ff @(posedge clock) begin
      if (do_write) mem[widx] <= new_w;
      if (rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vld_ff       <= '0;
         rvld_ff      <= 1'b0;
         top_ff       <= '0;
         cnt_ff       <= '0;
         size_ff      <= MAX_SIZE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rd_en) rvld_ff <= vld_ff[raddr];
         if (csr_we) begin
            size_ff <= csr_wdata;
            vld_ff  <= '0;
            top_ff  <= '0;
            cnt_ff  <= '0;
         end else begin
            if (do_clear) vld_ff <= '0;
            else if (do_write) vld_ff[widx] <= 1'b1;
            top_ff <= top_in;
            cnt_ff <= cnt_in;
         end
         if (finish) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_type;
         pos_ff   <= pos_in;
         early_ff <= early_in;
      end
      if (go_desc) jdx_ff <= jdx_in;
      if (finish) begin
         rsp_success_ff      <= res_success;
         rsp_answer_ff       <= res_answer;
         rsp_member_count_ff <= cnt_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_success      = rsp_success_ff;
   assign rsp_answer       = rsp_answer_ff;
   assign rsp_member_count = rsp_member_count_ff;

   // a non-empty set always has a summary bit set
   a_count_summary: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (top_ff != '0))
      else $error("member count without summary bit");

   // count never exceeds the admissible size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= size_eff)
      else $error("member count above universe size");

   // descent only follows a leaf inspection
   a_desc_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DESC) && $past(state_ff != S_DESC) |-> $past(state_ff == S_LEAF))
      else $error("descent without leaf step");

   // a stalled result is never overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      finish |-> !out_busy)
      else $error("result register overrun");
endmodule

// File: dv/hbis_checker.sv
// checker for the hierarchical bitmap integer set: predicts each result and compares it
`timescale 1ns / 1ps
module hbis_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [hbis_pkg::OP_W-1:0]          req_type,
   input  logic signed [hbis_pkg::KEY_W-1:0]  req_key,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic                               rsp_success,
   input  logic signed [hbis_pkg::KEY_W-1:0]  rsp_answer,
   input  logic [hbis_pkg::SIZE_W-1:0]        rsp_member_count,
   input  logic                               csr_we,
   input  logic [hbis_pkg::SIZE_W-1:0]        csr_wdata,
   output int                                 fail_count,
   output int                                 pending
);
   import hbis_pkg::*;

   typedef struct packed {
      logic                    success;
      logic signed [KEY_W-1:0] answer;
      logic [SIZE_W-1:0]       count;
   } set_result_type;

   // flat membership array; the tree is only a speedup, so a flat scan is exact
   logic [MAX_UNIVERSE-1:0] member_bits;
   int                      member_total;
   int                      size_limit;
   set_result_type          expected_q[$];

   assign pending = expected_q.size();

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic set_result_type apply_request(input logic [OP_W-1:0] op,
                                                    input logic signed [KEY_W-1:0] key_in);
      set_result_type r;
      int             k;
      int             i;
      bit             in_range;
      k = key_in;
      r = '0;
      in_range = (k >= 0) && (k < size_limit);
      case (op)
         OP_INSERT: if (in_range && !member_bits[k]) begin
            member_bits[k] = 1'b1;
            member_total++;
            r.success = 1'b1;
         end
         OP_ERASE: if (in_range && member_bits[k]) begin
            member_bits[k] = 1'b0;
            member_total--;
            r.success = 1'b1;
         end
         OP_CONTAINS: r.success = in_range && member_bits[k];
         OP_SUCC: begin
            r.answer = KEY_W'(size_limit);
            for (i = (k < 0 ? 0 : k + 1); i < size_limit; i++)
               if (member_bits[i]) begin
                  r.answer = KEY_W'(i);
                  break;
               end
         end
         OP_PRED: begin
            r.answer = '1;
            if (k >= 0)
               for (i = (k >= size_limit ? size_limit : k) - 1; i >= 0; i--)
                  if (member_bits[i]) begin
                     r.answer = KEY_W'(i);
                     break;
                  end
         end
         OP_CLEAR: begin
            member_bits = '0;
            member_total = 0;
         end
         default: ;
      endcase
      r.count = SIZE_W'(member_total);
      return r;
   endfunction

   always @(posedge clock) begin
      set_result_type want;
      if (reset) begin
         member_bits = '0;
         member_total = 0;
         size_limit = MAX_UNIVERSE;
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            member_bits = '0;
            member_total = 0;
            size_limit = (csr_wdata > MAX_UNIVERSE) ? MAX_UNIVERSE : csr_wdata;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_success !== want.success)
                  report_mismatch("success", rsp_success, want.success);
               if (rsp_answer !== want.answer)
                  report_mismatch("answer", rsp_answer, want.answer);
               if (rsp_member_count !== want.count)
                  report_mismatch("member count", rsp_member_count, want.count);
            end
         end
         if (req_valid && !req_stall)
            expected_q.insert(expected_q.size(), apply_request(req_type, req_key));
      end
   end
endmodule

// File: dv/hierarchical_bitmap_integer_set_top_tb.sv
// testbench top for the hierarchical bitmap integer set: stimulus and verdict
`timescale 1ns / 1ps
module hierarchical_bitmap_integer_set_top_tb;
   import hbis_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   // request codes with no operation behind them
   localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [OP_W-1:0]         req_type = OP_CONTAINS;
   logic signed [KEY_W-1:0] req_key = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_success;
   logic signed [KEY_W-1:0] rsp_answer;
   logic [SIZE_W-1:0]       rsp_member_count;
   logic                    csr_we = 1'b0;
   logic [SIZE_W-1:0]       csr_wdata = '0;
   int                      fail_count;
   int                      pending;

   // idle odds in percent; the receiver process reads its own
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_off = 1'b0;
   int  cycle_count = 0;
   int  cur_size = MAX_UNIVERSE;

   always #1 clock = ~clock;

   hierarchical_bitmap_integer_set_top dut (.*);

   hbis_checker checker_i (.*);

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver stall process, with a long counted hold-off when asked
   initial begin
      int held;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            for (held = 0; held < 300; held++) @(negedge clock);
            hold_off = 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // offer one request and wait for its acceptance; valid stays up for the next one
   task automatic send_request(input logic [OP_W-1:0] op, input int key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_key <= KEY_W'(key);
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // stop offering, wait until every result is in, plus drain margin
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_size(input int value);
      drain_results();
      csr_we <= 1'b1;
      csr_wdata <= SIZE_W'(value);
      cur_size = value > MAX_UNIVERSE ? MAX_UNIVERSE : value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // keys mostly in range, with edges and out-of-range noise
   function automatic int pick_key();
      int sel;
      sel = $urandom_range(99);
      if (sel < 5) return -1;
      if (sel < 8) return $urandom_range(16383) - 8192;
      if (sel < 12) return cur_size + $urandom_range(3);
      if (sel < 20) return (cur_size == 0) ? 0 : cur_size - 1 - $urandom_range(2);
      if (sel < 25) return $urandom_range(8191);
      if (cur_size == 0) return 0;
      return $urandom_range(cur_size - 1);
   endfunction

   task automatic random_phase(input int count);
      int n;
      int r;
      logic [OP_W-1:0] op;
      for (n = 0; n < count; n++) begin
         r = $urandom_range(99);
         // insert-heavy so searches see populated trees; rare clear and unused codes
         if (r < 35) op = OP_INSERT;
         else if (r < 50) op = OP_ERASE;
         else if (r < 62) op = OP_CONTAINS;
         else if (r < 78) op = OP_SUCC;
         else if (r < 94) op = OP_PRED;
         else if (r < 96) op = OP_CLEAR;
         else op = OP_W'($urandom_range(7));
         send_request(op, pick_key());
      end
   endtask

   initial begin
      int i;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty searches, extremes, bad keys, every code
      send_request(OP_SUCC, -1);
      send_request(OP_PRED, 4096);
      send_request(OP_INSERT, 0);
      send_request(OP_INSERT, 4095);
      send_request(OP_INSERT, 0);
      send_request(OP_INSERT, -1);
      send_request(OP_INSERT, 4096);
      send_request(OP_INSERT, 8191);
      send_request(OP_INSERT, -8192);
      send_request(OP_INSERT, 130);
      send_request(OP_CONTAINS, 4095);
      send_request(OP_SUCC, -8192);
      send_request(OP_SUCC, 130);
      send_request(OP_PRED, 8191);
      send_request(OP_PRED, 0);
      send_request(OP_PRED, 130);
      send_request(OP_ERASE, 130);
      send_request(OP_ERASE, 130);
      send_request(OP_SPARE6, 5);
      send_request(OP_SPARE7, 5);
      send_request(OP_CLEAR, 77);
      send_request(OP_CONTAINS, 0);

      // empty universe, then a size above the cap, which is held at 4096
      write_size(0);
      send_request(OP_INSERT, 0);
      send_request(OP_SUCC, -1);
      send_request(OP_PRED, 5);
      write_size(8191);
      send_request(OP_INSERT, 4095);
      send_request(OP_PRED, 8191);

      send_idle_pct = 37;
      recv_idle_pct = 55;
      write_size(64);
      random_phase(300);
      write_size(1000);
      random_phase(350);

      // long receiver hold-off while the sender keeps offering
      hold_off = 1'b1;
      random_phase(50);
      drain_results();

      send_idle_pct = 55;
      recv_idle_pct = 37;
      write_size(4096);
      random_phase(500);
      write_size(1);
      random_phase(100);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_size(4095);
      random_phase(500);
      write_size(200);
      random_phase(200);

      drain_results();
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule

// File: sim.f
sv/hbis_pkg.sv
sv/hierarchical_bitmap_integer_set_top.sv
dv/hbis_checker.sv
dv/hierarchical_bitmap_integer_set_top_tb.sv
